[hw/rtl/sftpg_pkg.sv]
// Package for the scaled font text pixel generator.
// Holds operation and register codes, fixed widths, the reciprocal table for
// the cell-width division and the 5x7 font ROM. No dependencies.
package sftpg_pkg;

  localparam int CODE_W    = 7;
  localparam int COORD_W   = 12;
  localparam int SLOT_W    = 5;
  localparam int SCALE_W   = 5;
  localparam int VCOUNT_W  = 6;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int MaxScale  = 16;

  // Reciprocal of the cell width: idx = (lx * recip) >> RECIP_SHIFT, exact for lx < 4096
  localparam int RECIP_W     = 17;
  localparam int RECIP_SHIFT = 19;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    REG_ORIGIN_X      = 2'd0,
    REG_ORIGIN_Y      = 2'd1,
    REG_GLYPH_SCALE   = 2'd2,
    REG_VISIBLE_COUNT = 2'd3
  } cfg_reg_t;

  // Five columns of eight bits, bit r is row r from the top
  typedef logic [0:4][7:0] glyph_t;

  // ceil(2^19 / (6 * s)) for s in 1..16
  function automatic logic [RECIP_W-1:0] cell_recip(input logic [SCALE_W-1:0] s);
    logic [RECIP_W-1:0] r;
    case (s)
      5'd1:    r = 17'd87382;
      5'd2:    r = 17'd43691;
      5'd3:    r = 17'd29128;
      5'd4:    r = 17'd21846;
      5'd5:    r = 17'd17477;
      5'd6:    r = 17'd14564;
      5'd7:    r = 17'd12484;
      5'd8:    r = 17'd10923;
      5'd9:    r = 17'd9710;
      5'd10:   r = 17'd8739;
      5'd11:   r = 17'd7944;
      5'd12:   r = 17'd7282;
      5'd13:   r = 17'd6722;
      5'd14:   r = 17'd6242;
      5'd15:   r = 17'd5826;
      5'd16:   r = 17'd5462;
      default: r = 17'd87382;
    endcase
    return r;
  endfunction

  // Codes without a glyph read as blank
  function automatic glyph_t font_glyph(input logic [CODE_W-1:0] code);
    glyph_t g;
    case (code)
      7'h21:   g = '{8'h00, 8'h00, 8'h5f, 8'h00, 8'h00}; // !
      7'h27:   g = '{8'h00, 8'h05, 8'h03, 8'h00, 8'h00}; // '
      7'h2e:   g = '{8'h00, 8'h60, 8'h60, 8'h00, 8'h00}; // .
      7'h3a:   g = '{8'h00, 8'h36, 8'h36, 8'h00, 8'h00}; // :
      7'h2d:   g = '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08}; // -
      7'h2f:   g = '{8'h20, 8'h10, 8'h08, 8'h04, 8'h02}; // /
      7'h30:   g = '{8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e};
      7'h31:   g = '{8'h00, 8'h42, 8'h7f, 8'h40, 8'h00};
      7'h32:   g = '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
      7'h33:   g = '{8'h21, 8'h41, 8'h45, 8'h4b, 8'h31};
      7'h34:   g = '{8'h18, 8'h14, 8'h12, 8'h7f, 8'h10};
      7'h35:   g = '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
      7'h36:   g = '{8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30};
      7'h37:   g = '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
      7'h38:   g = '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
      7'h39:   g = '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1e};
      7'h3f:   g = '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06}; // ?
      7'h5f:   g = '{8'h40, 8'h40, 8'h40, 8'h40, 8'h40}; // _
      7'h41:   g = '{8'h7e, 8'h11, 8'h11, 8'h11, 8'h7e};
      7'h42:   g = '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h36};
      7'h43:   g = '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h22};
      7'h44:   g = '{8'h7f, 8'h41, 8'h41, 8'h22, 8'h1c};
      7'h45:   g = '{8'h7f, 8'h49, 8'h49, 8'h49, 8'h41};
      7'h46:   g = '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h01};
      7'h47:   g = '{8'h3e, 8'h41, 8'h49, 8'h49, 8'h7a};
      7'h48:   g = '{8'h7f, 8'h08, 8'h08, 8'h08, 8'h7f};
      7'h49:   g = '{8'h00, 8'h41, 8'h7f, 8'h41, 8'h00};
      7'h4a:   g = '{8'h20, 8'h40, 8'h41, 8'h3f, 8'h01};
      7'h4b:   g = '{8'h7f, 8'h08, 8'h14, 8'h22, 8'h41};
      7'h4c:   g = '{8'h7f, 8'h40, 8'h40, 8'h40, 8'h40};
      7'h4d:   g = '{8'h7f, 8'h02, 8'h0c, 8'h02, 8'h7f};
      7'h4e:   g = '{8'h7f, 8'h04, 8'h08, 8'h10, 8'h7f};
      7'h4f:   g = '{8'h3e, 8'h41, 8'h41, 8'h41, 8'h3e};
      7'h50:   g = '{8'h7f, 8'h09, 8'h09, 8'h09, 8'h06};
      7'h51:   g = '{8'h3e, 8'h41, 8'h51, 8'h21, 8'h5e};
      7'h52:   g = '{8'h7f, 8'h09, 8'h19, 8'h29, 8'h46};
      7'h53:   g = '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
      7'h54:   g = '{8'h01, 8'h01, 8'h7f, 8'h01, 8'h01};
      7'h55:   g = '{8'h3f, 8'h40, 8'h40, 8'h40, 8'h3f};
      7'h56:   g = '{8'h1f, 8'h20, 8'h40, 8'h20, 8'h1f};
      7'h57:   g = '{8'h3f, 8'h40, 8'h38, 8'h40, 8'h3f};
      7'h58:   g = '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
      7'h59:   g = '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07};
      7'h5a:   g = '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

[hw/rtl/sftpg_text_buf.sv]
// Text buffer: one-write, one-read memory of character codes with registered read.
// Per-entry valid bits clear at reset, so unwritten entries read as zero.
// Depends on sftpg_pkg.
module sftpg_text_buf #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [sftpg_pkg::CODE_W-1:0] wr_code,
  input  logic                         rd_en,
  input  logic [AW-1:0]                rd_addr,
  output logic [sftpg_pkg::CODE_W-1:0] rd_code
);
  import sftpg_pkg::*;

  logic [CODE_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]  vld_r;
  logic [CODE_W-1:0] rd_data_r;
  logic              rd_vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rd_vld_r  <= vld_r[rd_addr];
    end
  end

  assign rd_code = rd_vld_r ? rd_data_r : '0;

endmodule

[hw/rtl/scaled_font_text_pixel_generator.sv]
// Scaled 5x7 text overlay: pixel queries in, one lit/unlit bit per query out.
// Queries pass stage 1, stage 2 and stage 3 and then the registered output.
// Throughput: one transaction per cycle unless out_stall holds the pipe; a character
// write leaves the pipe at the buffer stage, the memory port shared in order with query reads.
// Reset: synchronous, clears config to defaults and the buffer valid bits at once.
module scaled_font_text_pixel_generator #(
  parameter int MAX_CHARS = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sftpg_pkg::PADDR_W-1:0]        paddr,
  input  logic [sftpg_pkg::PDATA_W-1:0]        pwdata,
  output logic [sftpg_pkg::PDATA_W-1:0]        prdata,
  output logic                                 pready,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_op,
  input  logic [sftpg_pkg::SLOT_W-1:0]         in_char_slot,
  input  logic [sftpg_pkg::CODE_W-1:0]         in_char_code,
  input  logic signed [sftpg_pkg::COORD_W-1:0] in_pixel_x,
  input  logic signed [sftpg_pkg::COORD_W-1:0] in_pixel_y,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_pixel_on
);
  import sftpg_pkg::*;

  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int IDX_W = 10;
  localparam logic [IDX_W-1:0] MaxCharsIdx = IDX_W'(MAX_CHARS);
  localparam logic [SLOT_W+4-1:0] MaxCharsSlot = (SLOT_W+4)'(MAX_CHARS);

  // ---------------- configuration ----------------
  logic [COORD_W-1:0]  origin_x_r, origin_y_r;
  logic [SCALE_W-1:0]  glyph_scale_r;
  logic [VCOUNT_W-1:0] visible_count_r;
  logic                cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r      <= '0;
      origin_y_r      <= '0;
      glyph_scale_r   <= SCALE_W'(1);
      visible_count_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_reg_t'(paddr[3:2]))
        REG_ORIGIN_X:      origin_x_r      <= pwdata[COORD_W-1:0];
        REG_ORIGIN_Y:      origin_y_r      <= pwdata[COORD_W-1:0];
        REG_GLYPH_SCALE:   glyph_scale_r   <= pwdata[SCALE_W-1:0];
        REG_VISIBLE_COUNT: visible_count_r <= pwdata[VCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_reg_t'(paddr[3:2]))
      REG_ORIGIN_X:      prdata = PDATA_W'(origin_x_r);
      REG_ORIGIN_Y:      prdata = PDATA_W'(origin_y_r);
      REG_GLYPH_SCALE:   prdata = PDATA_W'(glyph_scale_r);
      REG_VISIBLE_COUNT: prdata = PDATA_W'(visible_count_r);
      default:           prdata = '0;
    endcase
  end

  // Effective scale and its multiples
  logic [SCALE_W-1:0] scale;
  logic [6:0]         thr [1:6];
  logic [RECIP_W-1:0] recip;

  always_comb begin
    if (glyph_scale_r == '0) begin
      scale = SCALE_W'(1);
    end else if (glyph_scale_r > SCALE_W'(MaxScale)) begin
      scale = SCALE_W'(MaxScale);
    end else begin
      scale = glyph_scale_r;
    end
    for (int k = 1; k <= 6; k++) begin
      thr[k] = 7'(7'(scale) * 7'(k));
    end
    recip = cell_recip(scale);
  end

  // ---------------- flow control ----------------
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic out_free, rdy3, rdy2, rdy1, in_acc, ld2, ld3;
  logic op2_r;

  assign out_free = !out_valid_r || !out_stall;
  assign rdy3     = !v3_r || out_free;
  // a write finishes in stage 2, so only a query needs room downstream
  assign rdy2     = !v2_r || (op2_r == OP_WRITE) || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_acc   = in_valid && rdy1;
  assign in_stall = !rdy1;
  assign ld2      = v1_r && rdy2;
  assign ld3      = v2_r && (op2_r == OP_QUERY) && rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_acc;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r && (op2_r == OP_QUERY);
      if (out_free) out_valid_r <= v3_r;
    end
  end

  // ---------------- stage 1: offsets from origin ----------------
  logic                  op1_r;
  logic [SLOT_W-1:0]     slot1_r;
  logic [CODE_W-1:0]     code1_r;
  logic [COORD_W:0]      lx1_r, ly1_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op1_r   <= in_op;
      slot1_r <= in_char_slot;
      code1_r <= in_char_code;
      lx1_r   <= {in_pixel_x[COORD_W-1], in_pixel_x} - {origin_x_r[COORD_W-1], origin_x_r};
      ly1_r   <= {in_pixel_y[COORD_W-1], in_pixel_y} - {origin_y_r[COORD_W-1], origin_y_r};
    end
  end

  // ---------------- stage 2: cell index by reciprocal multiply ----------------
  logic [COORD_W+RECIP_W-1:0] prod;
  logic                       early1;
  logic [SLOT_W-1:0]          slot2_r;
  logic [CODE_W-1:0]          code2_r;
  logic [COORD_W-1:0]         lx2_r;
  logic [6:0]                 ly2_r;
  logic [IDX_W-1:0]           idx2_r;
  logic                       early2_r;

  assign prod   = (COORD_W+RECIP_W)'(lx1_r[COORD_W-1:0]) * (COORD_W+RECIP_W)'(recip);
  // above or left of the origin, or below the text row
  assign early1 = lx1_r[COORD_W] || ly1_r[COORD_W] ||
                  (ly1_r[COORD_W-1:0] >= COORD_W'(thr[6] + 7'(scale)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op2_r <= OP_WRITE;
    end else if (ld2) begin
      op2_r <= op1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      slot2_r  <= slot1_r;
      code2_r  <= code1_r;
      lx2_r    <= lx1_r[COORD_W-1:0];
      ly2_r    <= ly1_r[6:0];
      idx2_r   <= prod[RECIP_SHIFT +: IDX_W];
      early2_r <= early1;
    end
  end

  // ---------------- stage 2: buffer access, column and row ----------------
  logic [16:0]       cell_base;
  logic [COORD_W-1:0] cx_full;
  logic [6:0]        cx;
  logic              gap, blank2;
  logic [2:0]        col2, row2;
  logic              buf_wr, buf_rd;
  logic [CODE_W-1:0] buf_code;

  always_comb begin
    cell_base = 17'(idx2_r) * 17'(thr[6]);
    cx_full   = lx2_r - COORD_W'(cell_base);
    cx        = cx_full[6:0];
    gap       = cx >= thr[5];
    col2      = 3'(cx >= thr[1]) + 3'(cx >= thr[2]) + 3'(cx >= thr[3]) + 3'(cx >= thr[4]);
    row2      = 3'(ly2_r >= thr[1]) + 3'(ly2_r >= thr[2]) + 3'(ly2_r >= thr[3]) +
                3'(ly2_r >= thr[4]) + 3'(ly2_r >= thr[5]) + 3'(ly2_r >= thr[6]);
    blank2    = early2_r || gap || (idx2_r >= IDX_W'(visible_count_r)) ||
                (idx2_r >= MaxCharsIdx);
  end

  assign buf_wr = v2_r && (op2_r == OP_WRITE) && ((SLOT_W+4)'(slot2_r) < MaxCharsSlot);
  assign buf_rd = ld3;

  sftpg_text_buf #(
    .DEPTH (MAX_CHARS),
    .AW    (AW)
  ) u_text_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (buf_wr),
    .wr_addr (AW'(slot2_r)),
    .wr_code (code2_r),
    .rd_en   (buf_rd),
    .rd_addr (AW'(idx2_r)),
    .rd_code (buf_code)
  );

  // ---------------- stage 3: font lookup ----------------
  logic       blank3_r;
  logic [2:0] col3_r, row3_r;
  glyph_t     glyph;
  logic       dot;

  always_ff @(posedge clk) begin
    if (ld3) begin
      blank3_r <= blank2;
      col3_r   <= col2;
      row3_r   <= row2;
    end
  end

  always_comb begin
    glyph = font_glyph(buf_code);
    dot   = !blank3_r && glyph[col3_r][row3_r];
  end

  logic out_pixel_on_r;

  always_ff @(posedge clk) begin
    if (out_free && v3_r) begin
      out_pixel_on_r <= dot;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pixel_on = out_pixel_on_r;

  // ---------------- assertions ----------------
  a_no_stall_when_out_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled while the output register is empty");

  a_result_from_stage3: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(v3_r))
    else $error("result appeared without a query in stage 3");

  a_single_buf_access: assert property (@(posedge clk) disable iff (!rst_n)
    !(buf_wr && buf_rd))
    else $error("buffer read and write in the same cycle");

  a_stage3_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && out_valid_r && out_stall) |=> v3_r)
    else $error("stage 3 query lost while the output was stalled");

  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("output valid after reset");

endmodule

[sim/testbench.sv]
// Self-checking testbench for the scaled font text pixel generator.
// Depends on sftpg_pkg and the scaled_font_text_pixel_generator top level; a small
// scoreboard class predicts pixel_on from its own font table, text buffer and registers.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import sftpg_pkg::*;

  localparam int TextCells = 32;
  localparam int SettleCycles = 8;

  typedef struct {
    int x;
    int y;
    bit lit;
  } lit_pixel_t;

  class pixel_scoreboard;
    logic [CODE_W-1:0]         cells [TextCells];
    logic signed [COORD_W-1:0] org_x;
    logic signed [COORD_W-1:0] org_y;
    logic [SCALE_W-1:0]        scale;
    logic [VCOUNT_W-1:0]       count;
    lit_pixel_t                lit_queue [$];
    int                        errors;

    function void reset_state();
      foreach (cells[i]) cells[i] = '0;
      org_x = '0;
      org_y = '0;
      scale = 5'd1;
      count = '0;
      lit_queue.delete();
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t r, logic [PDATA_W-1:0] v);
      case (r)
        REG_ORIGIN_X:      org_x = v[COORD_W-1:0];
        REG_ORIGIN_Y:      org_y = v[COORD_W-1:0];
        REG_GLYPH_SCALE:   scale = v[SCALE_W-1:0];
        REG_VISIBLE_COUNT: count = v[VCOUNT_W-1:0];
        default: ;
      endcase
    endfunction

    function int eff_scale();
      int s;
      s = int'(scale);
      if (s < 1) s = 1;
      if (s > MaxScale) s = MaxScale;
      return s;
    endfunction

    // Five columns packed first to last, bit r of a column is row r
    function logic [7:0] glyph_column(logic [CODE_W-1:0] code, int col);
      logic [39:0] g;
      case (code)
        7'h21:   g = 40'h00_00_5f_00_00;
        7'h27:   g = 40'h00_05_03_00_00;
        7'h2e:   g = 40'h00_60_60_00_00;
        7'h3a:   g = 40'h00_36_36_00_00;
        7'h2d:   g = 40'h08_08_08_08_08;
        7'h2f:   g = 40'h20_10_08_04_02;
        7'h30:   g = 40'h3e_51_49_45_3e;
        7'h31:   g = 40'h00_42_7f_40_00;
        7'h32:   g = 40'h42_61_51_49_46;
        7'h33:   g = 40'h21_41_45_4b_31;
        7'h34:   g = 40'h18_14_12_7f_10;
        7'h35:   g = 40'h27_45_45_45_39;
        7'h36:   g = 40'h3c_4a_49_49_30;
        7'h37:   g = 40'h01_71_09_05_03;
        7'h38:   g = 40'h36_49_49_49_36;
        7'h39:   g = 40'h06_49_49_29_1e;
        7'h3f:   g = 40'h02_01_51_09_06;
        7'h5f:   g = 40'h40_40_40_40_40;
        7'h41:   g = 40'h7e_11_11_11_7e;
        7'h42:   g = 40'h7f_49_49_49_36;
        7'h43:   g = 40'h3e_41_41_41_22;
        7'h44:   g = 40'h7f_41_41_22_1c;
        7'h45:   g = 40'h7f_49_49_49_41;
        7'h46:   g = 40'h7f_09_09_09_01;
        7'h47:   g = 40'h3e_41_49_49_7a;
        7'h48:   g = 40'h7f_08_08_08_7f;
        7'h49:   g = 40'h00_41_7f_41_00;
        7'h4a:   g = 40'h20_40_41_3f_01;
        7'h4b:   g = 40'h7f_08_14_22_41;
        7'h4c:   g = 40'h7f_40_40_40_40;
        7'h4d:   g = 40'h7f_02_0c_02_7f;
        7'h4e:   g = 40'h7f_04_08_10_7f;
        7'h4f:   g = 40'h3e_41_41_41_3e;
        7'h50:   g = 40'h7f_09_09_09_06;
        7'h51:   g = 40'h3e_41_51_21_5e;
        7'h52:   g = 40'h7f_09_19_29_46;
        7'h53:   g = 40'h46_49_49_49_31;
        7'h54:   g = 40'h01_01_7f_01_01;
        7'h55:   g = 40'h3f_40_40_40_3f;
        7'h56:   g = 40'h1f_20_40_20_1f;
        7'h57:   g = 40'h3f_40_38_40_3f;
        7'h58:   g = 40'h63_14_08_14_63;
        7'h59:   g = 40'h07_08_70_08_07;
        7'h5a:   g = 40'h61_51_49_45_43;
        default: g = '0;
      endcase
      return g[39-8*col -: 8];
    endfunction

    function bit pixel_lit(logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
      int s, lx, ly, cw, idx, cx;
      logic [7:0] column;
      s  = eff_scale();
      lx = int'(px) - int'(org_x);
      ly = int'(py) - int'(org_y);
      if (lx < 0 || ly < 0 || ly >= 7 * s) return 1'b0;
      cw  = 6 * s;
      idx = lx / cw;
      if (idx >= int'(count) || idx >= TextCells) return 1'b0;
      if (cells[idx] == '0) return 1'b0;
      cx = lx % cw;
      if (cx >= 5 * s) return 1'b0;
      column = glyph_column(cells[idx], cx / s);
      return column[ly / s];
    endfunction

    function void note_input(op_t op, logic [SLOT_W-1:0] slot, logic [CODE_W-1:0] code,
                             logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
      lit_pixel_t e;
      if (op == OP_WRITE) begin
        cells[slot] = code;
      end else begin
        e.x   = int'(px);
        e.y   = int'(py);
        e.lit = pixel_lit(px, py);
        lit_queue.push_back(e);
      end
    endfunction

    function void check_result(logic got);
      lit_pixel_t e;
      if (lit_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected pixel_on result %0b", got);
      end else begin
        e = lit_queue.pop_front();
        if (got !== e.lit) begin
          errors++;
          if (errors <= 10)
            $display("pixel_on mismatch at (%0d,%0d): expected %0b, got %0b",
                     e.x, e.y, e.lit, got);
        end
      end
    endfunction

    function int pending();
      return lit_queue.size();
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic [PADDR_W-1:0]          paddr;
  logic [PDATA_W-1:0]          pwdata;
  logic [PDATA_W-1:0]          prdata;
  logic                        pready;
  logic                        in_valid;
  logic                        in_stall;
  logic                        in_op;
  logic [SLOT_W-1:0]           in_char_slot;
  logic [CODE_W-1:0]           in_char_code;
  logic signed [COORD_W-1:0]   in_pixel_x;
  logic signed [COORD_W-1:0]   in_pixel_y;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_pixel_on;

  pixel_scoreboard sb = new();
  bit send_quiet;
  bit recv_quiet;
  int hold_reqs;
  int hold_done;
  int stall_left;
  int free_left;

  scaled_font_text_pixel_generator #(.MAX_CHARS(TextCells)) u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_char_slot (in_char_slot),
    .in_char_code (in_char_code),
    .in_pixel_x   (in_pixel_x),
    .in_pixel_y   (in_pixel_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pixel_on (out_pixel_on)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Result side: take a transaction, then choose the stall for the next cycle
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
      free_left  = 0;
      hold_done  = hold_reqs;
    end else begin
      if (out_valid && !out_stall) sb.check_result(out_pixel_on);
      if (hold_reqs != hold_done) begin
        hold_done  = hold_reqs;
        stall_left = 400;
        free_left  = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (free_left > 0 || recv_quiet) begin
        out_stall <= 1'b0;
        if (free_left > 0) free_left--;
      end else begin
        out_stall  <= 1'b0;
        stall_left = pick_gap(1'b0);
        free_left  = $urandom_range(0, 20);
      end
    end
  end

  task automatic send_item(op_t op, logic [SLOT_W-1:0] slot, logic [CODE_W-1:0] code,
                           logic signed [COORD_W-1:0] px, logic signed [COORD_W-1:0] py);
    int gap;
    gap = pick_gap(send_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_op        <= op;
    in_char_slot <= slot;
    in_char_code <= code;
    in_pixel_x   <= px;
    in_pixel_y   <= py;
    do @(posedge clk); while (in_stall);
    sb.note_input(op, slot, code, px, py);
  endtask

  // Unused fields carry random values so the block is seen to ignore them
  task automatic send_write(int slot, int code);
    int rx, ry;
    rx = $urandom;
    ry = $urandom;
    send_item(OP_WRITE, slot[SLOT_W-1:0], code[CODE_W-1:0],
              rx[COORD_W-1:0], ry[COORD_W-1:0]);
  endtask

  task automatic send_query(int x, int y);
    int rs, rc;
    rs = $urandom;
    rc = $urandom;
    send_item(OP_QUERY, rs[SLOT_W-1:0], rc[CODE_W-1:0], x[COORD_W-1:0], y[COORD_W-1:0]);
  endtask

  // Drop valid, wait for every outstanding result, then let the pipe settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t r, int value);
    logic [PDATA_W-1:0] w;
    w = value;
    w[PDATA_W-1:16] = (PDATA_W-16)'($urandom);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({r, 2'b00});
    pwdata  <= w;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(r, w);
    @(posedge clk);
  endtask

  task automatic configure(int ox, int oy, int sc, int vc);
    wait_idle();
    cfg_write(REG_ORIGIN_X, ox);
    cfg_write(REG_ORIGIN_Y, oy);
    cfg_write(REG_GLYPH_SCALE, sc);
    cfg_write(REG_VISIBLE_COUNT, vc);
  endtask

  function automatic int pick_code();
    string glyphs;
    int r;
    glyphs = " !'.:-/0123456789?_ABCDEFGHIJKLMNOPQRSTUVWXYZ";
    r = $urandom_range(0, 99);
    if (r < 70) return int'(glyphs[$urandom_range(0, glyphs.len() - 1)]);
    if (r < 85) return 0;
    return $urandom_range(0, 127);
  endfunction

  task automatic run_items(int n);
    int i, r, s, span, len, x, y, cells_drawn;
    i = 0;
    while (i < n) begin
      s = sb.eff_scale();
      cells_drawn = (int'(sb.count) < TextCells) ? int'(sb.count) : TextCells;
      span = cells_drawn * 6 * s + 8;
      r = $urandom_range(0, 99);
      if (r < 25) begin
        send_write($urandom_range(0, TextCells - 1), pick_code());
        i++;
      end else if (r < 70) begin
        send_query(int'(sb.org_x) + $urandom_range(0, span) - 4,
                   int'(sb.org_y) + $urandom_range(0, 7 * s + 3) - 2);
        i++;
      end else if (r < 88) begin
        // short raster run along one row
        len = $urandom_range(4, 16);
        x = int'(sb.org_x) + $urandom_range(0, span) - 4;
        y = int'(sb.org_y) + $urandom_range(0, 7 * s + 1) - 1;
        repeat (len) begin
          send_query(x, y);
          x++;
        end
        i += len;
      end else begin
        send_query($urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048);
        i++;
      end
    end
  endtask

  task automatic fill_text();
    int n;
    n = $urandom_range(3, 10);
    for (int k = 0; k < n; k++) send_write(k, pick_code());
  endtask

  initial begin
    #6_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    rst_n        <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    in_valid     <= 1'b0;
    in_op        <= OP_WRITE;
    in_char_slot <= '0;
    in_char_code <= '0;
    in_pixel_x   <= '0;
    in_pixel_y   <= '0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    hold_reqs  = 0;
    sb.reset_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Nothing is drawn while the visible count is at its reset value
    send_query(0, 1);
    send_write(0, 8'h41);
    send_write(1, 0);
    send_write(2, 8'h30);
    send_write(3, 8'h7f);
    send_write(31, 8'h48);
    send_query(0, 1);

    configure(0, 0, 1, 32);
    send_query(0, 0);
    send_query(0, 1);
    send_query(-1, 1);
    send_query(1, -1);
    send_query(0, 7);
    send_query(5, 1);
    send_query(7, 1);
    send_query(12, 1);
    send_query(18, 3);
    send_query(186, 0);
    send_query(192, 0);
    send_query(2047, 2047);
    send_query(-2048, -2048);

    configure(0, 0, 1, 3);
    send_query(186, 0);
    send_query(12, 1);

    for (int p = 0; p < 10; p++) begin
      case (p)
        0: configure(-2048, -2048, 0, 63);
        1: configure(2047, 2047, 16, 32);
        2: configure(-30, -5, 17, 1);
        3: configure(5, 5, 3, 0);
        4: configure(-20, 3, 31, 32);
        default: configure($urandom_range(0, 600) - 300, $urandom_range(0, 600) - 300,
                           ($urandom_range(0, 99) < 70) ? $urandom_range(1, 4)
                                                        : $urandom_range(0, 31),
                           $urandom_range(0, 40));
      endcase
      send_quiet = (p == 2 || p == 4 || p == 7);
      recv_quiet = (p == 2 || p == 7);
      // hold the result side off so the block backs up onto its input
      if (p == 4) hold_reqs++;
      fill_text();
      if (p == 6) begin
        run_items(40);
        wait_idle();
        run_items(40);
      end else begin
        run_items(75);
      end
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
